FILE: hw/rtl/tsdi_pkg.sv
package tsdi_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;   // index / position field width
  localparam int PTR_W        = 7;   // holds any count or index up to 64

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STAT_LOADED   = 2'd0,
    STAT_DELETED  = 2'd1,
    STAT_INSERTED = 2'd2,
    STAT_REFUSED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_LIST,
    ST_EMPTY
  } state_t;

  // chain control, broadcast to every cell
  typedef struct packed {
    logic                shift;  // every cell takes its right neighbor
    logic                push;   // write wdata into the cell at tgt
    logic [PTR_W-1:0]    tgt;
    logic [DATA_W-1:0]   wdata;
  } chain_ctl_t;

endpackage

FILE: hw/rtl/tsdi_cell.sv
module tsdi_cell
  import tsdi_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [DATA_W-1:0] nbr_data,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_r;

  // push wins over shift; tgt already accounts for the shift in the same cycle
  always_ff @(posedge clk) begin
    if (ctl.push && (ctl.tgt == PTR_W'(IDX))) begin
      data_r <= ctl.wdata;
    end else if (ctl.shift) begin
      data_r <= nbr_data;
    end
  end

  assign data = data_r;

endmodule

FILE: hw/rtl/tsdi_chain.sv
module tsdi_chain
  import tsdi_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_nbr  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_end
      assign cell_nbr[i] = '0;
    end else begin : g_mid
      assign cell_nbr[i] = cell_data[i+1];
    end

    tsdi_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .nbr_data (cell_nbr[i]),
      .data     (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

endmodule

FILE: hw/rtl/table_search_delete_insert_top.sv
// Channel | Dir | tuser                     | tdata                           | tlast
// in_     | in  | mode                      | value[31:0], position[37:32]    | -
// out_    | out | status[1:0], elem_vld[2] | index[5:0], element[37:6]       | last
//
// Entries sit in a row of cells that shift toward cell 0 one place a cycle when the head
// is popped; the head cell is the only read port, so every pass walks the table once.
// Load: accept, then the start state emits the beat and goes back to idle, raising in_tready.
// Query with n entries: a start state, a search pass rotating all n entries, a decision
// step, then a rebuild pass that also places an inserted entry, one beat per cycle except
// for the deleted entry while out_ is not stalled; an empty result table gets one beat.
// Reset clears the state, the entry count and out_tvalid; cell contents are not reset.
// A stalled out_ beat holds the rebuild pass; in_ beats are taken only when idle.
module table_search_delete_insert_top
  import tsdi_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[37:32], zero pad
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // index[5:0], element[37:6], zero pad
  output logic [2:0]  out_tuser,  // status[1:0], element_valid[2]
  output logic        out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      ecnt_r, ecnt_nxt;
  logic [CW-1:0]      nnew_r, nnew_nxt;
  logic [IDX_W-1:0]   m_r, m_nxt;
  logic               found_r, found_nxt;
  logic               pend_r, pend_nxt;
  status_t            status_r, status_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               mode_r;
  logic [DATA_W-1:0]  value_r;
  logic [IDX_W-1:0]   pos_r;

  logic               out_valid_r;
  status_t            o_status_r;
  logic [IDX_W-1:0]   o_index_r;
  logic [DATA_W-1:0]  o_elem_r;
  logic               o_ev_r;
  logic               o_last_r;

  logic               emit;
  status_t            e_status;
  logic [IDX_W-1:0]   e_index;
  logic [DATA_W-1:0]  e_elem;
  logic               e_ev;
  logic               e_last;

  logic               can_emit;
  logic               in_fire;
  logic               pop;
  logic               push;
  logic [DATA_W-1:0]  push_data;
  logic [DATA_W-1:0]  head_data;
  chain_ctl_t         ctl;
  logic               refuse;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign can_emit  = !out_valid_r || out_tready;
  assign refuse    = (occ_r >= CW'(CAPACITY)) ||
                     (PTR_W'(pos_r) > PTR_W'(occ_r));

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    ecnt_nxt   = ecnt_r;
    nnew_nxt   = nnew_r;
    m_nxt      = m_r;
    found_nxt  = found_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    pop        = 1'b0;
    push       = 1'b0;
    push_data  = head_data;
    emit       = 1'b0;
    e_status   = status_r;
    e_index    = idx_r;
    e_elem     = head_data;
    e_ev       = 1'b1;
    e_last     = ((ecnt_r + CW'(1)) == nnew_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (mode_r == MODE_QUERY) begin
          n_nxt     = occ_r;
          k_nxt     = '0;
          found_nxt = 1'b0;
          m_nxt     = '0;
          state_nxt = ST_SEARCH;
        end else if (can_emit) begin
          emit    = 1'b1;
          e_index = IDX_W'(occ_r);
          e_elem  = value_r;
          e_last  = 1'b1;
          if (occ_r >= CW'(CAPACITY)) begin
            e_status = STAT_REFUSED;
            e_ev     = 1'b0;
          end else begin
            e_status  = STAT_LOADED;
            push      = 1'b1;
            push_data = value_r;
            occ_nxt   = occ_r + CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (k_r < n_r) begin
          // rotate head to tail so the order is back after n steps
          pop  = 1'b1;
          push = 1'b1;
          if (!found_r && (head_data == value_r)) begin
            found_nxt = 1'b1;
            m_nxt     = IDX_W'(k_r);
          end
          k_nxt = k_r + CW'(1);
        end else begin
          k_nxt    = '0;
          ecnt_nxt = '0;
          pend_nxt = 1'b0;
          if (found_r) begin
            status_nxt = STAT_DELETED;
            idx_nxt    = m_r;
            nnew_nxt   = n_r - CW'(1);
          end else if (refuse) begin
            status_nxt = STAT_REFUSED;
            idx_nxt    = pos_r;
            nnew_nxt   = n_r;
          end else begin
            status_nxt = STAT_INSERTED;
            idx_nxt    = pos_r;
            nnew_nxt   = n_r + CW'(1);
            pend_nxt   = 1'b1;
          end
          if (nnew_nxt == '0) begin
            // table ends up empty: nothing to rebuild
            occ_nxt   = '0;
            state_nxt = ST_EMPTY;
          end else begin
            state_nxt = ST_LIST;
          end
        end
      end
      ST_LIST: begin
        if (can_emit) begin
          if (pend_r && (PTR_W'(k_r) == PTR_W'(pos_r))) begin
            push      = 1'b1;
            push_data = value_r;
            emit      = 1'b1;
            e_elem    = value_r;
            pend_nxt  = 1'b0;
            ecnt_nxt  = ecnt_r + CW'(1);
            occ_nxt   = occ_r + CW'(1);
          end else if (k_r < n_r) begin
            pop   = 1'b1;
            k_nxt = k_r + CW'(1);
            if ((status_r == STAT_DELETED) && (PTR_W'(k_r) == PTR_W'(m_r))) begin
              occ_nxt = occ_r - CW'(1);
            end else begin
              push     = 1'b1;
              emit     = 1'b1;
              ecnt_nxt = ecnt_r + CW'(1);
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_elem    = '0;
          e_ev      = 1'b0;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // tail slot moves down by one when the head leaves in the same cycle
  assign ctl = {pop, push, PTR_W'(occ_r) - PTR_W'(pop), push_data};

  tsdi_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .head_data (head_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    ecnt_r   <= ecnt_nxt;
    nnew_r   <= nnew_nxt;
    m_r      <= m_nxt;
    found_r  <= found_nxt;
    pend_r   <= pend_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    if (in_fire) begin
      mode_r  <= in_tuser;
      value_r <= in_tdata[31:0];
      pos_r   <= in_tdata[37:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_status_r <= e_status;
      o_index_r  <= e_index;
      o_elem_r   <= e_elem;
      o_ev_r     <= e_ev;
      o_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_elem_r, o_index_r};
  assign out_tuser  = {o_ev_r, o_status_r};
  assign out_tlast  = o_last_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_search_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) && (state_nxt == ST_SEARCH) |=> $stable(occ_r))
    else $error("search rotation changed the entry count");

  a_list_final_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) && (state_nxt == ST_IDLE) |=> occ_r == $past(nnew_r))
    else $error("rebuild left a wrong entry count");

  a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> can_emit)
    else $error("beat issued while output register is held");
`endif

endmodule

FILE: test/table_search_checker.sv
`timescale 1ns / 1ps

module table_search_checker
  import tsdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          pending_beats,
  output int          beats_checked
);

  localparam int TABLE_DEPTH = CAPACITY_DEF;

  typedef struct {
    status_t     status;
    logic [5:0]  index;
    logic [31:0] element;
    logic        elem_vld;
    logic        last;
  } list_beat_t;

  logic [31:0] shadow_entries [TABLE_DEPTH];
  int          shadow_count;
  list_beat_t  expected_beats [$];

  initial begin
    shadow_count   = 0;
    mismatch_count = 0;
    pending_beats  = 0;
    beats_checked  = 0;
  end

  function automatic list_beat_t make_beat(status_t st, logic [5:0] idx, logic [31:0] elem,
                                           logic vld, logic lst);
    list_beat_t b;
    b.status   = st;
    b.index    = idx;
    b.element  = elem;
    b.elem_vld = vld;
    b.last     = lst;
    return b;
  endfunction

  // Updates the shadow table for one input beat and queues the beats it must produce.
  task automatic apply_table_op(input logic mode, input logic [31:0] value,
                                input logic [5:0] pos);
    int      hit;
    status_t st;
    logic [5:0] idx;
    hit = -1;
    if (mode == MODE_LOAD) begin
      if (shadow_count >= TABLE_DEPTH) begin
        expected_beats.push_back(make_beat(STAT_REFUSED, 6'(shadow_count), value, 1'b0, 1'b1));
      end else begin
        shadow_entries[shadow_count] = value;
        expected_beats.push_back(make_beat(STAT_LOADED, 6'(shadow_count), value, 1'b1, 1'b1));
        shadow_count++;
      end
      return;
    end
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_entries[i] == value) hit = i;
    end
    if (hit >= 0) begin
      for (int i = hit + 1; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
      shadow_count--;
      st  = STAT_DELETED;
      idx = 6'(hit);
    end else if (shadow_count >= TABLE_DEPTH || int'(pos) > shadow_count) begin
      st  = STAT_REFUSED;
      idx = pos;
    end else begin
      for (int i = shadow_count; i > int'(pos); i--) shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[pos] = value;
      shadow_count++;
      st  = STAT_INSERTED;
      idx = pos;
    end
    // empty table still answers with one marker beat
    if (shadow_count == 0) begin
      expected_beats.push_back(make_beat(st, idx, 32'd0, 1'b0, 1'b1));
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        expected_beats.push_back(make_beat(st, idx, shadow_entries[i], 1'b1,
                                           i == shadow_count - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    list_beat_t want;
    list_beat_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = make_beat(status_t'(out_tuser[1:0]), out_tdata[5:0], out_tdata[37:6],
                        out_tuser[2], out_tlast);
        beats_checked++;
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected out beat: status=%0d index=%0d element=%h vld=%b last=%b",
                     $realtime, got.status, got.index, got.element, got.elem_vld, got.last);
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.element !== want.element || got.elem_vld !== want.elem_vld ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: out beat mismatch: exp status=%0d index=%0d element=%h ",
                        "vld=%b last=%b / got status=%0d index=%0d element=%h vld=%b last=%b"},
                       $realtime, want.status, want.index, want.element, want.elem_vld,
                       want.last, got.status, got.index, got.element, got.elem_vld, got.last);
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_table_op(in_tuser, in_tdata[31:0], in_tdata[37:32]);
      pending_beats = expected_beats.size();
    end
  end

endmodule

FILE: test/tb_table_search_delete_insert_top.sv
`timescale 1ns / 1ps

module tb_table_search_delete_insert_top;
  import tsdi_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int   mismatch_count;
  int   pending_beats;
  int   beats_checked;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   loads_sent;
  int   queries_sent;
  logic in_fire;

  table_search_delete_insert_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  table_search_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .pending_beats (pending_beats),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  // cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d beats outstanding",
               QUIET_LIMIT, pending_beats);
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(input logic mode, input logic [31:0] value, input logic [5:0] pos);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, pos, value};
    do @(negedge clk); while (!in_fire);
    if (mode == MODE_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_beats != 0);
  endtask

  // mostly a small pool so queries hit often; some extremes and full-range values
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($signed($urandom_range(0, 11)) - 6);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [5:0] pick_pos();
    if ($urandom_range(0, 99) < 80) return 6'($urandom_range(0, 33));
    return 6'($urandom_range(0, 63));
  endfunction

  // load-heavy stretch fills the table, query-heavy stretch drains it
  task automatic run_phase(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < 36; i++)
      send_item(($urandom_range(0, 99) < 90) ? MODE_LOAD : MODE_QUERY, pick_value(), pick_pos());
    for (int i = 0; i < 20; i++)
      send_item(($urandom_range(0, 99) < 10) ? MODE_LOAD : MODE_QUERY, pick_value(), pick_pos());
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_LOAD;
    out_tready   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    loads_sent   = 0;
    queries_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty table: refused insert, insert at 0, then delete back to empty
    send_item(MODE_QUERY, 32'd5, 6'd1);
    send_item(MODE_QUERY, 32'd5, 6'd0);
    send_item(MODE_QUERY, 32'd5, 6'd0);
    send_item(MODE_LOAD, 32'h8000_0000, 6'd0);
    send_item(MODE_LOAD, 32'h7FFF_FFFF, 6'd63);
    send_item(MODE_LOAD, 32'h0000_0000, 6'd21);
    send_item(MODE_LOAD, 32'hFFFF_FFFF, 6'd42);
    send_item(MODE_QUERY, 32'h0000_0000, 6'd9);
    send_item(MODE_QUERY, 32'd7, 6'd3);          // position equals count
    send_item(MODE_QUERY, 32'd8, 6'd0);
    send_item(MODE_QUERY, 32'd9, 6'd6);          // position past count
    send_item(MODE_QUERY, 32'd9, 6'd63);
    send_item(MODE_LOAD, 32'd7, 6'd0);           // duplicate, first match wins
    send_item(MODE_QUERY, 32'd7, 6'd0);
    send_item(MODE_QUERY, 32'h7FFF_FFFF, 6'd2);
    send_item(MODE_QUERY, 32'h8000_0000, 6'd0);
    send_item(MODE_LOAD, 32'h5555_5555, 6'd63);
    send_item(MODE_LOAD, 32'hAAAA_AAAA, 6'd42);
    send_item(MODE_QUERY, 32'h1234_5678, 6'd32);
    wait_drained();

    run_phase(0, 0);
    run_phase(75, 0);
    run_phase(0, 75);
    run_phase(32, 32);

    in_tvalid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d items (%0d loads, %0d queries), checked %0d result beats",
             loads_sent + queries_sent, loads_sent, queries_sent, beats_checked);
    $display("fill and drain stretches under no idling, sender gaps, receiver stalls and both");
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
